// ----- src/ctshp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctshp_pkg
// shared widths, shape and pair codes, and pipeline stage types for the
// two-shape collision test
// ----------------------------------------------------------------------------
package ctshp_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    localparam int SQ_WIDTH    = 2 * COORD_WIDTH;

    localparam logic [1:0] SHAPE_POINT  = 2'd0;
    localparam logic [1:0] SHAPE_RECT   = 2'd1;
    localparam logic [1:0] SHAPE_CIRCLE = 2'd2;
    localparam logic [1:0] SHAPE_NONE   = 2'd3;

    localparam logic [2:0] PAIR_NONE = 3'd0;
    localparam logic [2:0] PAIR_PP   = 3'd1;
    localparam logic [2:0] PAIR_PR   = 3'd2;
    localparam logic [2:0] PAIR_PC   = 3'd3;
    localparam logic [2:0] PAIR_RR   = 3'd4;
    localparam logic [2:0] PAIR_RC   = 3'd5;
    localparam logic [2:0] PAIR_CC   = 3'd6;

    // centre differences and raw sizes
    typedef struct packed {
        logic [1:0]                  kind_a;
        logic [1:0]                  kind_b;
        logic signed [COORD_WIDTH:0] diff_x;
        logic signed [COORD_WIDTH:0] diff_y;
        logic [SIZE_WIDTH-1:0]       size_aw;
        logic [SIZE_WIDTH-1:0]       size_ah;
        logic [SIZE_WIDTH-1:0]       size_bw;
        logic [SIZE_WIDTH-1:0]       size_bh;
    } stage1_t;

    // distances, size sums and roles
    typedef struct packed {
        logic [2:0]             pair;
        logic [COORD_WIDTH-1:0] dist_x;
        logic [COORD_WIDTH-1:0] dist_y;
        logic [COORD_WIDTH-1:0] sum_w;
        logic [COORD_WIDTH-1:0] sum_h;
        logic [SIZE_WIDTH-1:0]  rect_w;
        logic [SIZE_WIDTH-1:0]  rect_h;
        logic [SIZE_WIDTH-1:0]  rad;
    } stage2_t;

    // decision or squarer operands
    typedef struct packed {
        logic                   early;
        logic                   early_hit;
        logic                   strict;
        logic [COORD_WIDTH-1:0] op_x;
        logic [COORD_WIDTH-1:0] op_y;
        logic [COORD_WIDTH-1:0] op_r;
    } stage3_t;

    typedef struct packed {
        logic                early;
        logic                early_hit;
        logic                strict;
        logic [SQ_WIDTH-1:0] sq_x;
        logic [SQ_WIDTH-1:0] sq_y;
        logic [SQ_WIDTH-1:0] sq_r;
    } stage4_t;

endpackage

// ----- src/collision_test_2d_shapes_core.sv -----
// ----------------------------------------------------------------------------
// collision_test_2d_shapes_core
// intersection test of two 2d shapes (point, centred rectangle, circle)
// ----------------------------------------------------------------------------
// One shape pair is taken per clock unless a stall on the output has filled
// every stage. The hit flag comes from five register stages, in order:
// centre subtraction, absolute value and size sums, bound compares with
// operand selection, three squarers, and the final add and compare.
// Stalls hold only the stages that cannot move, so empty stages keep filling
// while a result waits on the output. A type code of none on either side
// always gives no hit.
module collision_test_2d_shapes_core
    import ctshp_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_shape_a,
    input  logic signed [COORD_WIDTH-1:0] s_center_ax,
    input  logic signed [COORD_WIDTH-1:0] s_center_ay,
    input  logic [SIZE_WIDTH-1:0]         s_size_aw,
    input  logic [SIZE_WIDTH-1:0]         s_size_ah,
    input  logic [1:0]                    s_shape_b,
    input  logic signed [COORD_WIDTH-1:0] s_center_bx,
    input  logic signed [COORD_WIDTH-1:0] s_center_by,
    input  logic [SIZE_WIDTH-1:0]         s_size_bw,
    input  logic [SIZE_WIDTH-1:0]         s_size_bh,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit
);

    logic    v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic    en1, en2, en3, en4, en5;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    stage3_t s3_reg, s3_next;
    stage4_t s4_reg, s4_next;
    logic    hit_reg, hit_next;

    // a stage moves when it is empty or the one after it moves
    assign en5 = !out_valid_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready = en1;
    assign m_valid = out_valid_reg;
    assign m_hit   = hit_reg;

    // stage 1: centre differences
    always_comb begin
        s1_next.kind_a  = s_shape_a;
        s1_next.kind_b  = s_shape_b;
        s1_next.diff_x  = {s_center_ax[COORD_WIDTH-1], s_center_ax}
                        - {s_center_bx[COORD_WIDTH-1], s_center_bx};
        s1_next.diff_y  = {s_center_ay[COORD_WIDTH-1], s_center_ay}
                        - {s_center_by[COORD_WIDTH-1], s_center_by};
        s1_next.size_aw = s_size_aw;
        s1_next.size_ah = s_size_ah;
        s1_next.size_bw = s_size_bw;
        s1_next.size_bh = s_size_bh;
    end

    // stage 2: magnitudes, sums and which side is rectangle or circle
    always_comb begin
        logic [COORD_WIDTH:0] neg_x;
        logic [COORD_WIDTH:0] neg_y;
        neg_x = ~s1_reg.diff_x + {{COORD_WIDTH{1'b0}}, 1'b1};
        neg_y = ~s1_reg.diff_y + {{COORD_WIDTH{1'b0}}, 1'b1};
        s2_next.dist_x = s1_reg.diff_x[COORD_WIDTH] ? neg_x[COORD_WIDTH-1:0]
                                                     : s1_reg.diff_x[COORD_WIDTH-1:0];
        s2_next.dist_y = s1_reg.diff_y[COORD_WIDTH] ? neg_y[COORD_WIDTH-1:0]
                                                     : s1_reg.diff_y[COORD_WIDTH-1:0];
        s2_next.sum_w  = {1'b0, s1_reg.size_aw} + {1'b0, s1_reg.size_bw};
        s2_next.sum_h  = {1'b0, s1_reg.size_ah} + {1'b0, s1_reg.size_bh};
        s2_next.rect_w = (s1_reg.kind_a == SHAPE_RECT) ? s1_reg.size_aw : s1_reg.size_bw;
        s2_next.rect_h = (s1_reg.kind_a == SHAPE_RECT) ? s1_reg.size_ah : s1_reg.size_bh;
        s2_next.rad    = (s1_reg.kind_a == SHAPE_CIRCLE) ? s1_reg.size_aw : s1_reg.size_bw;
        case ({s1_reg.kind_a, s1_reg.kind_b})
            {SHAPE_POINT, SHAPE_POINT}:                              s2_next.pair = PAIR_PP;
            {SHAPE_POINT, SHAPE_RECT}, {SHAPE_RECT, SHAPE_POINT}:     s2_next.pair = PAIR_PR;
            {SHAPE_POINT, SHAPE_CIRCLE}, {SHAPE_CIRCLE, SHAPE_POINT}: s2_next.pair = PAIR_PC;
            {SHAPE_RECT, SHAPE_RECT}:                                s2_next.pair = PAIR_RR;
            {SHAPE_RECT, SHAPE_CIRCLE}, {SHAPE_CIRCLE, SHAPE_RECT}:   s2_next.pair = PAIR_RC;
            {SHAPE_CIRCLE, SHAPE_CIRCLE}:                            s2_next.pair = PAIR_CC;
            default:                                                 s2_next.pair = PAIR_NONE;
        endcase
    end

    // stage 3: bound tests in doubled coordinates, squarer operands
    always_comb begin
        logic [COORD_WIDTH:0]   dx2, dy2, hw, hh, reach_w, reach_h, corner_x, corner_y;
        logic [COORD_WIDTH-1:0] rr;
        logic                   in_w, in_h;
        dx2      = {s2_reg.dist_x, 1'b0};
        dy2      = {s2_reg.dist_y, 1'b0};
        hw       = {2'b00, s2_reg.rect_w};
        hh       = {2'b00, s2_reg.rect_h};
        rr       = {s2_reg.rad, 1'b0};
        reach_w  = hw + {1'b0, rr};
        reach_h  = hh + {1'b0, rr};
        corner_x = dx2 - hw;
        corner_y = dy2 - hh;
        in_w     = dx2 <= hw;
        in_h     = dy2 <= hh;
        s3_next.early     = 1'b1;
        s3_next.early_hit = 1'b0;
        s3_next.strict    = 1'b1;
        s3_next.op_x      = s2_reg.dist_x;
        s3_next.op_y      = s2_reg.dist_y;
        s3_next.op_r      = {1'b0, s2_reg.rad};
        case (s2_reg.pair)
            PAIR_PP: s3_next.early_hit = (s2_reg.dist_x == '0) && (s2_reg.dist_y == '0);
            PAIR_PR: s3_next.early_hit = in_w && in_h;
            PAIR_RR: s3_next.early_hit = (dx2 <= {1'b0, s2_reg.sum_w})
                                      && (dy2 <= {1'b0, s2_reg.sum_h});
            PAIR_PC: s3_next.early = 1'b0;
            PAIR_CC: begin
                s3_next.early = 1'b0;
                s3_next.op_r  = s2_reg.sum_w;
            end
            PAIR_RC: begin
                if (dx2 > reach_w || dy2 > reach_h) begin
                    s3_next.early_hit = 1'b0;
                end else if (in_w || in_h) begin
                    s3_next.early_hit = 1'b1;
                end else begin
                    // corner region, inclusive distance check
                    s3_next.early  = 1'b0;
                    s3_next.strict = 1'b0;
                    s3_next.op_x   = corner_x[COORD_WIDTH-1:0];
                    s3_next.op_y   = corner_y[COORD_WIDTH-1:0];
                    s3_next.op_r   = rr;
                end
            end
            default: s3_next.early_hit = 1'b0;
        endcase
    end

    // stage 4: squarers
    always_comb begin
        s4_next.early     = s3_reg.early;
        s4_next.early_hit = s3_reg.early_hit;
        s4_next.strict    = s3_reg.strict;
        s4_next.sq_x      = SQ_WIDTH'(s3_reg.op_x) * SQ_WIDTH'(s3_reg.op_x);
        s4_next.sq_y      = SQ_WIDTH'(s3_reg.op_y) * SQ_WIDTH'(s3_reg.op_y);
        s4_next.sq_r      = SQ_WIDTH'(s3_reg.op_r) * SQ_WIDTH'(s3_reg.op_r);
    end

    // stage 5: distance against radius
    always_comb begin
        logic [SQ_WIDTH:0] d2, r2;
        d2 = {1'b0, s4_reg.sq_x} + {1'b0, s4_reg.sq_y};
        r2 = {1'b0, s4_reg.sq_r};
        if (s4_reg.early) begin
            hit_next = s4_reg.early_hit;
        end else if (s4_reg.strict) begin
            hit_next = d2 < r2;
        end else begin
            hit_next = d2 <= r2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) v1_reg        <= s_valid;
            if (en2) v2_reg        <= v1_reg;
            if (en3) v3_reg        <= v2_reg;
            if (en4) v4_reg        <= v3_reg;
            if (en5) out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) s1_reg  <= s1_next;
        if (en2) s2_reg  <= s2_next;
        if (en3) s3_reg  <= s3_next;
        if (en4) s4_reg  <= s4_next;
        if (en5) hit_reg <= hit_next;
    end

    // input held off only when every stage is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg))
        else $error("input stalled with a free pipeline stage");

    // coincident points decide without the squarers
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && en3 && s2_reg.pair == PAIR_PP && s2_reg.dist_x == '0
         && s2_reg.dist_y == '0) |=> (s3_reg.early && s3_reg.early_hit))
        else $error("coincident points not reported as a hit");

    // a new output beat must come from the last inner stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(v4_reg))
        else $error("output beat appeared from an empty stage");

endmodule

// ----- tb/collision_test_2d_shapes_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// collision_test_2d_shapes_core_tb
// self-checking bench for the two-shape collision test
// ----------------------------------------------------------------------------
// A directed table covers every pairing of shape types, the none type, edge
// and boundary touches and the coordinate and size extremes. A random part
// follows with shape pairs placed close together at several scales, plus
// some fully random pairs. Every hit flag is checked in order against
// the expected value of its table row or an in-bench geometry predictor.
// Both sides insert random gaps, with quiet stretches at full rate.
// ----------------------------------------------------------------------------
module collision_test_2d_shapes_core_tb
    import ctshp_pkg::*;
();

    localparam int CMAX        = 8388607;
    localparam int CMIN        = -8388608;
    localparam int SMAX        = 8388607;
    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]                    kind_a;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic [SIZE_WIDTH-1:0]         aw;
        logic [SIZE_WIDTH-1:0]         ah;
        logic [1:0]                    kind_b;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic [SIZE_WIDTH-1:0]         bw;
        logic [SIZE_WIDTH-1:0]         bh;
    } pair_t;

    typedef struct {
        pair_t pair;
        logic  typed;
        logic  want;
    } row_t;

    logic  aclk     = 1'b0;
    logic  aresetn  = 1'b0;
    logic  s_valid  = 1'b0;
    logic  m_ready  = 1'b0;
    pair_t pair_in  = '0;
    logic  s_ready;
    logic  m_valid;
    logic  m_hit;

    logic  expected_hits[$];
    row_t  shape_table[$];
    bit    quiet    = 1'b0;
    int    sent_count = 0;
    int    hit_count  = 0;
    int    miss_count = 0;
    int    fail_count = 0;
    int    cycle_count = 0;

    collision_test_2d_shapes_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_shape_a   (pair_in.kind_a),
        .s_center_ax (pair_in.ax),
        .s_center_ay (pair_in.ay),
        .s_size_aw   (pair_in.aw),
        .s_size_ah   (pair_in.ah),
        .s_shape_b   (pair_in.kind_b),
        .s_center_bx (pair_in.bx),
        .s_center_by (pair_in.by),
        .s_size_bw   (pair_in.bw),
        .s_size_bh   (pair_in.bh),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // geometry predictor, all positions doubled so half sizes stay exact
    // ------------------------------------------------------------------
    function automatic logic [127:0] sq128(longint unsigned v);
        logic [127:0] w;
        w = {64'd0, v};
        return w * w;
    endfunction

    function automatic longint unsigned mag_diff(longint a, longint b);
        longint d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic point_in_rect(longint px, longint py, longint rx, longint ry,
                                           longint rw, longint rh);
        return !(px < rx - rw || py < ry - rh || px > rx + rw || py > ry + rh);
    endfunction

    function automatic logic point_in_circle(longint px, longint py, longint cx, longint cy,
                                             longint r);
        return (sq128(mag_diff(px, cx)) + sq128(mag_diff(py, cy))) < sq128(2 * r);
    endfunction

    function automatic logic rects_overlap(longint ax, longint ay, longint aw, longint ah,
                                           longint bx, longint by, longint bw, longint bh);
        return !(ax + aw < bx - bw || ay + ah < by - bh ||
                 ax - aw > bx + bw || ay - ah > by + bh);
    endfunction

    function automatic logic rect_meets_circle(longint rx, longint ry, longint rw, longint rh,
                                               longint cx, longint cy, longint r);
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned hw;
        longint unsigned hh;
        longint unsigned rr;
        dx = mag_diff(cx, rx);
        dy = mag_diff(cy, ry);
        hw = rw;
        hh = rh;
        rr = 2 * r;
        if (dx > hw + rr) return 1'b0;
        if (dy > hh + rr) return 1'b0;
        if (dx <= hw) return 1'b1;
        if (dy <= hh) return 1'b1;
        // corner region: distance to the nearest corner, boundary counts
        return (sq128(dx - hw) + sq128(dy - hh)) <= sq128(rr);
    endfunction

    function automatic logic predict_hit(pair_t p);
        longint ax;
        longint ay;
        longint aw;
        longint ah;
        longint bx;
        longint by;
        longint bw;
        longint bh;
        logic   hit;
        ax  = 2 * longint'($signed(p.ax));
        ay  = 2 * longint'($signed(p.ay));
        bx  = 2 * longint'($signed(p.bx));
        by  = 2 * longint'($signed(p.by));
        aw  = longint'(p.aw);
        ah  = longint'(p.ah);
        bw  = longint'(p.bw);
        bh  = longint'(p.bh);
        hit = 1'b0;
        case (p.kind_a)
            SHAPE_POINT: begin
                case (p.kind_b)
                    SHAPE_POINT:  hit = (ax == bx) && (ay == by);
                    SHAPE_RECT:   hit = point_in_rect(ax, ay, bx, by, bw, bh);
                    SHAPE_CIRCLE: hit = point_in_circle(ax, ay, bx, by, bw);
                    default: ;
                endcase
            end
            SHAPE_RECT: begin
                case (p.kind_b)
                    SHAPE_POINT:  hit = point_in_rect(bx, by, ax, ay, aw, ah);
                    SHAPE_RECT:   hit = rects_overlap(ax, ay, aw, ah, bx, by, bw, bh);
                    SHAPE_CIRCLE: hit = rect_meets_circle(ax, ay, aw, ah, bx, by, bw);
                    default: ;
                endcase
            end
            SHAPE_CIRCLE: begin
                case (p.kind_b)
                    SHAPE_POINT:  hit = point_in_circle(bx, by, ax, ay, aw);
                    SHAPE_RECT:   hit = rect_meets_circle(bx, by, bw, bh, ax, ay, aw);
                    SHAPE_CIRCLE: begin
                        hit = (sq128(mag_diff(ax, bx)) + sq128(mag_diff(ay, by)))
                              < sq128(2 * (aw + bw));
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic pair_t mk(logic [1:0] ka, int ax, int ay, int aw, int ah,
                                 logic [1:0] kb, int bx, int by, int bw, int bh);
        pair_t p;
        p.kind_a = ka;
        p.ax     = ax[COORD_WIDTH-1:0];
        p.ay     = ay[COORD_WIDTH-1:0];
        p.aw     = aw[SIZE_WIDTH-1:0];
        p.ah     = ah[SIZE_WIDTH-1:0];
        p.kind_b = kb;
        p.bx     = bx[COORD_WIDTH-1:0];
        p.by     = by[COORD_WIDTH-1:0];
        p.bw     = bw[SIZE_WIDTH-1:0];
        p.bh     = bh[SIZE_WIDTH-1:0];
        return p;
    endfunction

    function automatic logic [1:0] rand_kind();
        // none is kept rare since it always misses
        if ($urandom_range(0, 9) == 0) return SHAPE_NONE;
        return 2'($urandom_range(0, 2));
    endfunction

    function automatic pair_t rand_pair();
        pair_t p;
        int    mode;
        int    span;
        mode     = $urandom_range(0, 7);
        p.kind_a = rand_kind();
        p.kind_b = rand_kind();
        p.ax     = COORD_WIDTH'($urandom());
        p.ay     = COORD_WIDTH'($urandom());
        if (mode == 0) begin
            p.aw = SIZE_WIDTH'($urandom());
            p.ah = SIZE_WIDTH'($urandom());
            p.bx = COORD_WIDTH'($urandom());
            p.by = COORD_WIDTH'($urandom());
            p.bw = SIZE_WIDTH'($urandom());
            p.bh = SIZE_WIDTH'($urandom());
        end else begin
            // second shape near the first so that both outcomes are common
            span = (mode < 4) ? 256 : (mode < 7) ? 65536 : 4194304;
            p.bx = p.ax + COORD_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
            p.by = p.ay + COORD_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
            if (mode == 1) p.by = p.ay;
            if (mode == 4) p.bx = p.ax;
            p.aw = SIZE_WIDTH'($urandom_range(0, span));
            p.ah = SIZE_WIDTH'($urandom_range(0, span));
            p.bw = SIZE_WIDTH'($urandom_range(0, span));
            p.bh = SIZE_WIDTH'($urandom_range(0, span));
        end
        return p;
    endfunction

    task automatic send_pair(input pair_t p, input logic typed, input logic want);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        pair_in <= p;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_hits.push_back(typed ? want : predict_hit(p));
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_hits.size() != 0) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // result side: random stall before each beat
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (aresetn == 1'b1);
        @(negedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $error("hit: unexpected beat, got %0b", m_hit);
                fail_count++;
            end else begin
                if (m_hit !== expected_hits[0]) begin
                    $error("hit: expected %0b, got %0b", expected_hits[0], m_hit);
                    fail_count++;
                end
                void'(expected_hits.pop_front());
            end
            if (m_hit === 1'b1) hit_count++;
            else miss_count++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_hits.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int n_directed;
        // type none on either side, then extremes with unused sizes set
        shape_table.push_back('{mk(SHAPE_NONE, 0, 0, 0, 0, SHAPE_POINT, 0, 0, 0, 0), 1, 0});
        shape_table.push_back('{mk(SHAPE_POINT, 0, 0, 0, 0, SHAPE_NONE, 0, 0, 0, 0), 1, 0});
        shape_table.push_back('{mk(SHAPE_NONE, 0, 0, SMAX, SMAX,
                                   SHAPE_NONE, 0, 0, SMAX, SMAX), 1, 0});
        shape_table.push_back('{mk(SHAPE_CIRCLE, 0, 0, SMAX, 0,
                                   SHAPE_NONE, 0, 0, SMAX, SMAX), 1, 0});
        shape_table.push_back('{mk(SHAPE_RECT, 0, 0, SMAX, SMAX,
                                   SHAPE_NONE, 0, 0, 0, 0), 1, 0});
        shape_table.push_back('{mk(SHAPE_POINT, CMAX, CMAX, SMAX, SMAX,
                                   SHAPE_POINT, CMAX, CMAX, 0, 0), 1, 1});
        shape_table.push_back('{mk(SHAPE_POINT, CMIN, CMIN, 0, 0,
                                   SHAPE_POINT, CMIN, CMIN, SMAX, SMAX), 1, 1});
        shape_table.push_back('{mk(SHAPE_POINT, CMIN, CMIN, 0, 0,
                                   SHAPE_POINT, CMAX, CMAX, 0, 0), 1, 0});
        // edges, boundaries and corners
        shape_table.push_back('{mk(SHAPE_POINT, 25600, 0, 0, 0,
                                   SHAPE_RECT, 0, 0, 51200, 512), 0, 0});
        shape_table.push_back('{mk(SHAPE_RECT, 0, 0, 51200, 512,
                                   SHAPE_POINT, 25601, 0, SMAX, SMAX), 0, 0});
        shape_table.push_back('{mk(SHAPE_POINT, 12800, 0, 0, 0,
                                   SHAPE_CIRCLE, 0, 0, 12800, SMAX), 0, 0});
        shape_table.push_back('{mk(SHAPE_CIRCLE, 0, 0, 12800, 0,
                                   SHAPE_POINT, 100, -100, 0, 0), 0, 0});
        shape_table.push_back('{mk(SHAPE_RECT, 0, 0, 25600, 25600,
                                   SHAPE_RECT, 25600, 0, 25600, 100), 0, 0});
        shape_table.push_back('{mk(SHAPE_RECT, -1000, -1000, 100, 100,
                                   SHAPE_RECT, 1000, 1000, 100, 100), 0, 0});
        shape_table.push_back('{mk(SHAPE_RECT, 0, 0, 2000, 2000,
                                   SHAPE_CIRCLE, 1700, 1700, 300, 0), 0, 0});
        shape_table.push_back('{mk(SHAPE_CIRCLE, 1700, -1700, 500, SMAX,
                                   SHAPE_RECT, 0, 0, 2000, 2000), 0, 0});
        shape_table.push_back('{mk(SHAPE_CIRCLE, 0, 0, 1000, 0,
                                   SHAPE_CIRCLE, 2000, 0, 1000, 0), 0, 0});
        shape_table.push_back('{mk(SHAPE_CIRCLE, 0, 0, 1000, 0,
                                   SHAPE_CIRCLE, 1999, 0, 1000, 0), 0, 0});
        // wide products at the corners of the coordinate range
        shape_table.push_back('{mk(SHAPE_CIRCLE, CMIN, CMIN, SMAX, 0,
                                   SHAPE_CIRCLE, CMAX, CMAX, SMAX, 0), 0, 0});
        shape_table.push_back('{mk(SHAPE_RECT, CMIN, CMIN, SMAX, SMAX,
                                   SHAPE_RECT, CMAX, CMAX, SMAX, SMAX), 0, 0});
        shape_table.push_back('{mk(SHAPE_RECT, CMAX, CMIN, SMAX, SMAX,
                                   SHAPE_CIRCLE, CMIN, CMAX, SMAX, SMAX), 0, 0});
        shape_table.push_back('{mk(SHAPE_POINT, 5, 5, 0, 0,
                                   SHAPE_CIRCLE, 5, 5, 0, 0), 0, 0});
        shape_table.push_back('{mk(SHAPE_POINT, -7, 9, 0, 0,
                                   SHAPE_RECT, -7, 9, 0, 0), 0, 0});
        shape_table.push_back('{mk(SHAPE_POINT, CMAX, CMIN, 0, 0,
                                   SHAPE_RECT, CMIN, CMAX, SMAX, SMAX), 0, 0});
        shape_table.push_back('{mk(SHAPE_CIRCLE, CMIN, 0, SMAX, SMAX,
                                   SHAPE_POINT, CMAX, 0, 0, 0), 0, 0});

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (shape_table[i]) begin
            send_pair(shape_table[i].pair, shape_table[i].typed, shape_table[i].want);
        end
        n_directed = sent_count;
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            // every third block of beats runs with no gaps on either side
            quiet = ((i / 150) % 3) == 2;
            if (i == N_RANDOM / 2) wait_drained();
            send_pair(rand_pair(), 1'b0, 1'b0);
        end
        quiet = 1'b0;

        wait_drained();
        repeat (10) @(negedge aclk);

        $display("%0d shape pairs sent, %0d from the directed table, %0d random",
                 sent_count, n_directed, sent_count - n_directed);
        $display("results seen: %0d hits, %0d misses, %0d mismatches",
                 hit_count, miss_count, fail_count);
        if (fail_count == 0 && expected_hits.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
